[sv/ils_pkg.sv]
// shared types, codes and sizes for the indexed linked list store
// depends on nothing; used by ils_seq and indexed_linked_list_store
package ils_pkg;

  // number of nodes in the node memory
  localparam int CAPACITY = 256;
  // address bits of the node memory and bits of a pointer that can hold the null marker
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PTR_W = $clog2(CAPACITY + 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [AW-1:0]    addr_t;

  localparam ptr_t NULL_PTR = ptr_t'(CAPACITY);

  // request codes
  localparam logic [2:0] ACT_READ    = 3'd0;
  localparam logic [2:0] ACT_INS_HD  = 3'd1;
  localparam logic [2:0] ACT_INS_TL  = 3'd2;
  localparam logic [2:0] ACT_INS_POS = 3'd3;
  localparam logic [2:0] ACT_DEL_POS = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // one result item
  typedef struct packed {
    logic signed [31:0] value;
    logic               found;
    logic [1:0]         status;
  } res_t;

  // link memory port request
  typedef struct packed {
    logic  we;
    addr_t waddr;
    ptr_t  wdata;
    addr_t raddr;
  } link_port_t;

  // value memory port request
  typedef struct packed {
    logic        we;
    addr_t       waddr;
    logic [31:0] wdata;
    addr_t       raddr;
  } val_port_t;

endpackage

[sv/ils_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// depends on nothing
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/ils_seq.sv]
// request sequencer: walks the node chain and reads, modifies and writes back the node memories
// depends on ils_pkg
module ils_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          action,
  input  logic signed [10:0]  position,
  input  logic signed [31:0]  item_value,
  output ils_pkg::link_port_t link_port,
  input  ils_pkg::ptr_t       link_rdata,
  output ils_pkg::val_port_t  val_port,
  input  logic [31:0]         val_rdata,
  output logic                res_valid,
  input  logic                res_ready,
  output ils_pkg::res_t       res
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ALLOC    = 4'd1;
  localparam logic [3:0] S_ALLOC_W  = 4'd2;
  localparam logic [3:0] S_INS_HEAD = 4'd3;
  localparam logic [3:0] S_WALK     = 4'd4;
  localparam logic [3:0] S_RD_W     = 4'd5;
  localparam logic [3:0] S_INS_NX   = 4'd6;
  localparam logic [3:0] S_INS_LK   = 4'd7;
  localparam logic [3:0] S_DEL_N    = 4'd8;
  localparam logic [3:0] S_DEL_NN   = 4'd9;
  localparam logic [3:0] S_DEL_FREE = 4'd10;
  localparam logic [3:0] S_DEL_HD   = 4'd11;
  localparam logic [3:0] S_DEL_HD_W = 4'd12;
  localparam logic [3:0] S_FIN      = 4'd13;

  logic [3:0]         state;
  logic [2:0]         act_r;
  logic [31:0]        val_r;
  logic               at_head;
  ils_pkg::ptr_t      remaining;
  ils_pkg::ptr_t      cur;
  logic               pend;
  ils_pkg::ptr_t      new_node;
  ils_pkg::ptr_t      n_reg;
  ils_pkg::ptr_t      head;
  ils_pkg::ptr_t      free_head;
  ils_pkg::ptr_t      hwm;
  ils_pkg::ptr_t      count;
  ils_pkg::res_t      res_r;

  ils_pkg::ptr_t      node;
  int                 pos_i;
  int                 cnt_i;
  int                 ins_i;

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_FIN);
  assign res       = res_r;

  // node under the walk: fresh link data when a step was issued last cycle
  assign node = pend ? link_rdata : cur;

  // request position decoding
  always_comb begin
    pos_i = int'(position);
    cnt_i = int'(count);
    ins_i = 0;
    if (action == ils_pkg::ACT_INS_TL) begin
      ins_i = cnt_i;
    end else if (action == ils_pkg::ACT_INS_POS) begin
      ins_i = (pos_i < 0) ? 0 : pos_i;
    end
  end

  // memory port drive
  always_comb begin
    link_port.we    = 1'b0;
    link_port.waddr = cur[ils_pkg::AW-1:0];
    link_port.wdata = head;
    link_port.raddr = node[ils_pkg::AW-1:0];
    val_port.we     = 1'b0;
    val_port.waddr  = new_node[ils_pkg::AW-1:0];
    val_port.wdata  = val_r;
    val_port.raddr  = node[ils_pkg::AW-1:0];
    unique case (state)
      S_ALLOC: begin
        link_port.raddr = free_head[ils_pkg::AW-1:0];
      end
      S_INS_HEAD: begin
        link_port.we    = 1'b1;
        link_port.waddr = new_node[ils_pkg::AW-1:0];
        link_port.wdata = head;
        val_port.we     = 1'b1;
      end
      S_INS_NX: begin
        link_port.we    = 1'b1;
        link_port.waddr = new_node[ils_pkg::AW-1:0];
        link_port.wdata = link_rdata;
        val_port.we     = 1'b1;
      end
      S_INS_LK: begin
        link_port.we    = 1'b1;
        link_port.waddr = cur[ils_pkg::AW-1:0];
        link_port.wdata = new_node;
      end
      S_DEL_N: begin
        link_port.raddr = link_rdata[ils_pkg::AW-1:0];
      end
      S_DEL_NN: begin
        link_port.we    = 1'b1;
        link_port.waddr = cur[ils_pkg::AW-1:0];
        link_port.wdata = link_rdata;
      end
      S_DEL_FREE: begin
        link_port.we    = 1'b1;
        link_port.waddr = n_reg[ils_pkg::AW-1:0];
        link_port.wdata = free_head;
      end
      S_DEL_HD: begin
        link_port.raddr = head[ils_pkg::AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      head      <= ils_pkg::NULL_PTR;
      free_head <= ils_pkg::NULL_PTR;
      hwm       <= '0;
      count     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_r        <= action;
            val_r        <= item_value;
            cur          <= head;
            pend         <= 1'b0;
            res_r.value  <= '0;
            res_r.found  <= 1'b0;
            res_r.status <= ils_pkg::ST_DONE;
            priority if (action == ils_pkg::ACT_READ) begin
              if (pos_i >= 0 && pos_i < cnt_i) begin
                remaining <= ils_pkg::ptr_t'(pos_i);
                state     <= S_WALK;
              end else begin
                res_r.status <= ils_pkg::ST_RANGE;
                state        <= S_FIN;
              end
            end else if (action == ils_pkg::ACT_INS_HD || action == ils_pkg::ACT_INS_TL ||
                         action == ils_pkg::ACT_INS_POS) begin
              if (count == ils_pkg::ptr_t'(ils_pkg::CAPACITY)) begin
                res_r.status <= ils_pkg::ST_FULL;
                state        <= S_FIN;
              end else if (ins_i > cnt_i) begin
                res_r.status <= ils_pkg::ST_RANGE;
                state        <= S_FIN;
              end else begin
                at_head   <= (ins_i == 0);
                remaining <= ils_pkg::ptr_t'(ins_i - 1);
                state     <= S_ALLOC;
              end
            end else if (action == ils_pkg::ACT_DEL_POS) begin
              if (pos_i < 0 || pos_i >= cnt_i) begin
                res_r.status <= ils_pkg::ST_RANGE;
                state        <= S_FIN;
              end else if (pos_i == 0) begin
                state <= S_DEL_HD;
              end else begin
                remaining <= ils_pkg::ptr_t'(pos_i - 1);
                state     <= S_WALK;
              end
            end else begin
              state <= S_FIN;
            end
          end
        end
        // take a node off the free chain, or the next never-used node
        S_ALLOC: begin
          if (free_head != ils_pkg::NULL_PTR) begin
            new_node <= free_head;
            state    <= S_ALLOC_W;
          end else begin
            new_node <= hwm;
            hwm      <= hwm + ils_pkg::ptr_t'(1);
            state    <= at_head ? S_INS_HEAD : S_WALK;
          end
        end
        S_ALLOC_W: begin
          free_head <= link_rdata;
          state     <= at_head ? S_INS_HEAD : S_WALK;
        end
        S_INS_HEAD: begin
          head  <= new_node;
          count <= count + ils_pkg::ptr_t'(1);
          state <= S_FIN;
        end
        // one link per cycle along the chain
        S_WALK: begin
          cur <= node;
          if (remaining != '0) begin
            pend      <= 1'b1;
            remaining <= remaining - ils_pkg::ptr_t'(1);
          end else begin
            pend <= 1'b0;
            if (act_r == ils_pkg::ACT_READ) begin
              state <= S_RD_W;
            end else if (act_r == ils_pkg::ACT_DEL_POS) begin
              state <= S_DEL_N;
            end else begin
              state <= S_INS_NX;
            end
          end
        end
        S_RD_W: begin
          res_r.value <= val_rdata;
          res_r.found <= 1'b1;
          state       <= S_FIN;
        end
        S_INS_NX: begin
          state <= S_INS_LK;
        end
        S_INS_LK: begin
          count <= count + ils_pkg::ptr_t'(1);
          state <= S_FIN;
        end
        // unlink the node after the predecessor
        S_DEL_N: begin
          n_reg <= link_rdata;
          state <= S_DEL_NN;
        end
        S_DEL_NN: begin
          state <= S_DEL_FREE;
        end
        S_DEL_FREE: begin
          free_head <= n_reg;
          count     <= count - ils_pkg::ptr_t'(1);
          state     <= S_FIN;
        end
        S_DEL_HD: begin
          n_reg <= head;
          state <= S_DEL_HD_W;
        end
        S_DEL_HD_W: begin
          head  <= link_rdata;
          state <= S_DEL_FREE;
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/indexed_linked_list_store.sv]
// a request refused at once goes straight to the result state; otherwise a request at
// position k walks k links (k-1 for insert and delete), one link memory read per cycle.
// one item at a time; the next is accepted the cycle after the previous result enters
// the output register
// reset empties the list at once; never-used nodes are handed out by a fill count, so there
// is no clearing pass.
module indexed_linked_list_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic signed [10:0] position,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_value,
  output logic               found,
  output logic [1:0]         status
);

  ils_pkg::link_port_t link_port;
  ils_pkg::val_port_t  val_port;
  ils_pkg::ptr_t       link_rdata;
  logic [31:0]         val_rdata;
  logic                res_valid;
  logic                res_ready;
  ils_pkg::res_t       res;

  // node link memory
  ils_ram #(
    .WIDTH (ils_pkg::PTR_W),
    .DEPTH (ils_pkg::CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_port.we),
    .waddr (link_port.waddr),
    .wdata (link_port.wdata),
    .raddr (link_port.raddr),
    .rdata (link_rdata)
  );

  // node value memory
  ils_ram #(
    .WIDTH (32),
    .DEPTH (ils_pkg::CAPACITY)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_port.we),
    .waddr (val_port.waddr),
    .wdata (val_port.wdata),
    .raddr (val_port.raddr),
    .rdata (val_rdata)
  );

  ils_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .position   (position),
    .item_value (item_value),
    .link_port  (link_port),
    .link_rdata (link_rdata),
    .val_port   (val_port),
    .val_rdata  (val_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register, free when empty or being taken
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      read_value <= res.value;
      found      <= res.found;
      status     <= res.status;
    end
  end

endmodule
